@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for the multi stack shared pool; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked property, disabled while reset is held
`define MSP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// clocked property that also holds during reset
`define MSP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define MSP_ASSERT(lbl, clk, rst_n, prop)
`define MSP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hdl/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg
// shared constants, types and helpers of the multi stack shared pool
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int NUM_STACKS = 4;

  localparam int SLOT_IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int STK_IW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SEL_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic {
    MSP_IDLE,
    MSP_EXEC
  } msp_state_t;

  // slot pointer, a cleared valid bit is null
  typedef struct packed {
    logic               valid;
    logic [SLOT_IW-1:0] idx;
  } slot_ptr_t;

  function automatic logic ptr_live(input slot_ptr_t p);
    return p.valid && (32'(p.idx) < NUM_SLOTS);
  endfunction

  // power-on link of slot i: next slot, null for the last one
  function automatic slot_ptr_t link_reset(input logic [SLOT_IW-1:0] i);
    slot_ptr_t r;
    r.valid = (32'(i) + 32'd1) < NUM_SLOTS;
    r.idx   = SLOT_IW'(32'(i) + 32'd1);
    return r;
  endfunction

  function automatic logic sel_ok(input logic [SEL_W-1:0] s);
    return 32'(s) < NUM_STACKS;
  endfunction

endpackage

`default_nettype wire

@@ hdl/msp_in_if.sv @@
// ----------------------------------------------------------------------------
// msp_in_if
// command channel: push or pop on one stack
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic [msp_pkg::SEL_W-1:0]           stack_select;
  logic signed [msp_pkg::DATA_W-1:0]   push_value;

  modport source (output valid, output command, output stack_select,
                  output push_value, input ready);
  modport sink   (input valid, input command, input stack_select,
                  input push_value, output ready);
endinterface

`default_nettype wire

@@ hdl/msp_out_if.sv @@
// ----------------------------------------------------------------------------
// msp_out_if
// result channel: status, popped word and flags
// ----------------------------------------------------------------------------
`default_nettype none

interface msp_out_if;
  logic                                valid;
  logic                                ready;
  logic [msp_pkg::STATUS_W-1:0]        status;
  logic signed [msp_pkg::DATA_W-1:0]   pop_value;
  logic                                pool_full;
  logic                                stack_empty;

  modport source (output valid, output status, output pop_value,
                  output pool_full, output stack_empty, input ready);
  modport sink   (input valid, input status, input pop_value,
                  input pool_full, input stack_empty, output ready);
endinterface

`default_nettype wire

@@ hdl/multi_stack_shared_pool.sv @@
// ----------------------------------------------------------------------------
// multi_stack_shared_pool
// several lifo stacks linked through one shared pool of slots
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one command per transfer: push push_value onto stack
//   stack_select, or pop that stack. out_ch gives exactly one result per
//   command: status (done, overflow, underflow), the popped word, and the
//   pool-full and stack-empty flags after the step.
//   in the accept cycle of a command the slot pointer is issued to the link
//   and data memories; then, in the execute state, their registered read
//   data is used to relink and the result is loaded into the output register.
//   the slot memories are read through registers, so a new command is taken
//   only after the previous one has left the execute state; out valid rises
//   with the commit that ends the execute state.
//   a command can be taken while the previous result still waits in the
//   output register; if that result is still stalled when the next command
//   completes, the block holds in its execute state until out_ch transfers.
//   reset (synchronous, active low) empties all stacks and chains every slot
//   into the free list in order; no clearing pass is needed, links that
//   were never written read as their power-on value through valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multi_stack_shared_pool (
  input  wire        clk,
  input  wire        rst_n,
  msp_in_if.sink     in_ch,
  msp_out_if.source  out_ch
);

  // control state
  msp_pkg::msp_state_t state_r, state_nxt;
  msp_pkg::slot_ptr_t  top_r [msp_pkg::NUM_STACKS];
  msp_pkg::slot_ptr_t  free_head_r;
  logic                link_written_r [msp_pkg::NUM_SLOTS];

  // slot memories
  msp_pkg::slot_ptr_t               link_mem [msp_pkg::NUM_SLOTS];
  logic signed [msp_pkg::DATA_W-1:0] data_mem [msp_pkg::NUM_SLOTS];

  // registered command
  logic                              cmd_r;
  logic [msp_pkg::SEL_W-1:0]         sel_r;
  logic signed [msp_pkg::DATA_W-1:0] val_r;

  // registered memory reads
  logic [msp_pkg::SLOT_IW-1:0]       rd_addr_r;
  msp_pkg::slot_ptr_t                link_q_r;
  logic                              link_wr_q_r;
  logic signed [msp_pkg::DATA_W-1:0] data_q_r;

  // output register
  logic                              out_valid_r;
  logic [msp_pkg::STATUS_W-1:0]      out_status_r;
  logic signed [msp_pkg::DATA_W-1:0] out_pop_value_r;
  logic                              out_pool_full_r;
  logic                              out_stack_empty_r;

  logic                         accept;
  logic                         commit;
  logic [msp_pkg::STK_IW-1:0]   in_stk;
  logic [msp_pkg::STK_IW-1:0]   stk;
  logic [msp_pkg::SLOT_IW-1:0]  rd_addr;
  msp_pkg::slot_ptr_t           link_rd;
  msp_pkg::slot_ptr_t           cur_top;
  logic                         cur_sel_ok;
  logic                         op_ok;

  // fsm: idle takes a command, exec commits once the output register is free
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    commit      = 1'b0;
    case (state_r)
      msp_pkg::MSP_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = msp_pkg::MSP_EXEC;
        end
      end
      msp_pkg::MSP_EXEC: begin
        if (!out_valid_r || out_ch.ready) begin
          commit    = 1'b1;
          state_nxt = msp_pkg::MSP_IDLE;
        end
      end
      default: begin
        state_nxt = msp_pkg::MSP_IDLE;
      end
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  // read address: free head for a push, the addressed top for a pop
  assign in_stk  = msp_pkg::STK_IW'(in_ch.stack_select);
  assign rd_addr = (in_ch.command == msp_pkg::CMD_POP) ? top_r[in_stk].idx
                                                       : free_head_r.idx;

  // exec-side view; reads and writes never share a cycle, so no forwarding
  assign stk        = msp_pkg::STK_IW'(sel_r);
  assign cur_sel_ok = msp_pkg::sel_ok(sel_r);
  assign cur_top    = top_r[stk];
  assign link_rd    = link_wr_q_r ? link_q_r : msp_pkg::link_reset(rd_addr_r);
  assign op_ok      = cur_sel_ok && ((cmd_r == msp_pkg::CMD_POP)
                                     ? msp_pkg::ptr_live(cur_top)
                                     : msp_pkg::ptr_live(free_head_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msp_pkg::MSP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command capture and registered memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_ch.command;
      sel_r       <= in_ch.stack_select;
      val_r       <= in_ch.push_value;
      rd_addr_r   <= rd_addr;
      link_q_r    <= link_mem[rd_addr];
      data_q_r    <= data_mem[rd_addr];
      link_wr_q_r <= link_written_r[rd_addr];
    end
  end

  // memory write back
  always_ff @(posedge clk) begin
    if (commit && op_ok) begin
      if (cmd_r == msp_pkg::CMD_POP) begin
        link_mem[rd_addr_r] <= free_head_r;
      end else begin
        link_mem[rd_addr_r] <= cur_top;
        data_mem[rd_addr_r] <= val_r;
      end
    end
  end

  // pointers and link valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < msp_pkg::NUM_STACKS; i++) begin
        top_r[i] <= '0;
      end
      for (int i = 0; i < msp_pkg::NUM_SLOTS; i++) begin
        link_written_r[i] <= 1'b0;
      end
      free_head_r <= '{valid: 1'b1, idx: '0};
    end else if (commit && op_ok) begin
      link_written_r[rd_addr_r] <= 1'b1;
      if (cmd_r == msp_pkg::CMD_POP) begin
        top_r[stk]  <= link_rd;
        free_head_r <= '{valid: 1'b1, idx: rd_addr_r};
      end else begin
        top_r[stk]  <= '{valid: 1'b1, idx: rd_addr_r};
        free_head_r <= link_rd;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (op_ok && cmd_r == msp_pkg::CMD_POP) begin
        out_status_r      <= msp_pkg::ST_DONE;
        out_pop_value_r   <= data_q_r;
        out_pool_full_r   <= 1'b0;
        out_stack_empty_r <= !msp_pkg::ptr_live(link_rd);
      end else if (op_ok) begin
        out_status_r      <= msp_pkg::ST_DONE;
        out_pop_value_r   <= '0;
        out_pool_full_r   <= !msp_pkg::ptr_live(link_rd);
        out_stack_empty_r <= 1'b0;
      end else begin
        out_status_r      <= (cmd_r == msp_pkg::CMD_POP) ? msp_pkg::ST_UNDERFLOW
                                                         : msp_pkg::ST_OVERFLOW;
        out_pop_value_r   <= (cmd_r == msp_pkg::CMD_POP) ? msp_pkg::MOST_NEG : '0;
        out_pool_full_r   <= !msp_pkg::ptr_live(free_head_r);
        out_stack_empty_r <= !cur_sel_ok || !msp_pkg::ptr_live(cur_top);
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.pop_value   = out_pop_value_r;
  assign out_ch.pool_full   = out_pool_full_r;
  assign out_ch.stack_empty = out_stack_empty_r;

  // assertions

  // a commit always leaves a result in the output register
  `MSP_ASSERT(a_commit_fills_out, clk, rst_n, commit |=> out_valid_r)

  // exec never lingers once the output register can take the result
  `MSP_ASSERT(a_exec_no_stall, clk, rst_n,
    (state_r == msp_pkg::MSP_EXEC && (!out_valid_r || out_ch.ready)) |=>
      (state_r == msp_pkg::MSP_IDLE))

  // a slot is never both the free head and the top of the stack just used
  `MSP_ASSERT(a_free_not_top, clk, rst_n,
    (commit && op_ok) |=> !(free_head_r.valid && top_r[stk].valid &&
                            free_head_r.idx == top_r[stk].idx))

  // a successful pop frees a slot, so the pool cannot report full
  `MSP_ASSERT(a_pop_not_full, clk, rst_n,
    (commit && op_ok && cmd_r == msp_pkg::CMD_POP) |=> !out_pool_full_r)

  // no command is taken while one is in execution
  `MSP_ASSERT_ALWAYS(a_single_item, clk,
    (state_r == msp_pkg::MSP_EXEC) |-> !accept)

endmodule

`default_nettype wire
